### sv/hsd_pkg.sv
// Package for the extended Hamming SECDED block decoder.
// Holds shared widths, register indexes, status codes and defaults.
// No dependencies.
package hsd_pkg;

    // Default largest code block length in bits (power of two)
    localparam int MAX_BLOCK_DEF = 16384;

    // Data bits per original character
    localparam int BITS_PER_CHAR = 8;

    // Clamp range for log2 of the block length
    localparam int LOG2_MIN = 3;
    localparam int LOG2_MAX = 14;

    // Configuration port widths
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // Register field widths
    localparam int BSL_W   = 4;
    localparam int CHAR_W  = 20;
    localparam int COUNT_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_LIMIT      = 1'b1;

    typedef logic [1:0] t_status;

    // Block status codes
    localparam t_status ST_CLEAN   = 2'd0;
    localparam t_status ST_FIXED   = 2'd1;
    localparam t_status ST_PARITY  = 2'd2;
    localparam t_status ST_DOUBLE  = 2'd3;

endpackage

### sv/hsd_if.sv
// Channel interfaces of the SECDED block decoder: code bit input,
// data bit output and configuration write channel. Depends on hsd_pkg.

interface hsd_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic code_bit;

    modport source (output valid, output mode, output code_bit, input ready);
    modport sink   (input valid, input mode, input code_bit, output ready);
endinterface

interface hsd_out_if;
    logic            valid;
    logic            ready;
    logic            data_bit;
    hsd_pkg::t_status block_status;
    logic            last_in_block;
    logic            last_data_bit;

    modport source (output valid, output data_bit, output block_status,
                    output last_in_block, output last_data_bit, input ready);
    modport sink   (input valid, input data_bit, input block_status,
                    input last_in_block, input last_data_bit, output ready);
endinterface

interface hsd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hsd_pkg::CFG_IDX_W-1:0]  index;
    logic [hsd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/hsd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read during a write to the same address returns the old contents.
// No dependencies.
module hsd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/hamming_secded_block_decoder_unit.sv
// Extended Hamming SECDED block decoder: one code bit or drain tick per cycle.
// One input transaction per cycle unless output stalls; result valid the cycle after accept.
// A block's data bits come out one per input transaction, starting with the one after it
// completes; the bit store read is prefetched from next state so the RAM port keeps pace.
// Reset (synchronous, active low) resets config and clears framing, counters and output valid;
// output payload and bit store are not cleared, no clearing pass is run.
module hamming_secded_block_decoder_unit #(
    parameter int MAX_BLOCK = hsd_pkg::MAX_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsd_in_if.sink      i_in,
    hsd_out_if.source   o_out,
    hsd_cfg_if.sink     i_cfg
);

    localparam int LOG2 = $clog2(MAX_BLOCK);
    localparam int PW   = LOG2 + 1;     // positions 0..MAX_BLOCK
    localparam int AW   = LOG2 + 1;     // bank bit plus offset
    localparam int KW   = 5;
    localparam int SH   = $clog2(hsd_pkg::BITS_PER_CHAR);

    // Configuration registers
    logic [hsd_pkg::BSL_W-1:0]  r_bsl, n_bsl;
    logic [hsd_pkg::CHAR_W-1:0] r_char, n_char;

    // Framing state
    logic                        r_bank, n_bank;
    logic [PW-1:0]               r_wp, n_wp;
    logic [PW-1:0]               r_rp, n_rp;
    logic [LOG2-1:0]             r_syn, n_syn;
    logic                        r_par, n_par;
    logic                        r_pend, n_pend;
    hsd_pkg::t_status            r_pst, n_pst;
    logic [PW-1:0]               r_ppos, n_ppos;
    logic [hsd_pkg::COUNT_W-1:0] r_cnt, n_cnt;

    // Output register
    logic             r_ovalid, n_ovalid;
    logic             r_obit, n_obit;
    hsd_pkg::t_status r_ost, n_ost;
    logic             r_olast_blk, n_olast_blk;
    logic             r_olast_dat, n_olast_dat;

    // Datapath signals
    logic                        in_acc;
    logic                        cfg_acc;
    logic [KW-1:0]               kk;
    logic [PW-1:0]               blen;
    logic [PW-1:0]               blen_m1;
    logic [hsd_pkg::COUNT_W-1:0] limit;
    logic [hsd_pkg::COUNT_W-1:0] cnt_inc;
    logic [PW-1:0]               p_next;
    logic [PW-1:0]               wpos;
    logic [LOG2-1:0]             syn_upd;
    logic                        par_upd;
    logic                        rd_bit;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [PW-1:0]               rofs;

    assign i_in.ready  = !r_ovalid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    // Clamp block size and form the block length
    always_comb begin
        kk = KW'(r_bsl);
        if (kk < KW'(hsd_pkg::LOG2_MIN)) begin
            kk = KW'(hsd_pkg::LOG2_MIN);
        end
        if (kk > KW'(hsd_pkg::LOG2_MAX)) begin
            kk = KW'(hsd_pkg::LOG2_MAX);
        end
        if (kk > KW'(LOG2)) begin
            kk = KW'(LOG2);
        end
        blen    = PW'(1) << kk;
        blen_m1 = blen - PW'(1);
    end

    assign limit   = hsd_pkg::COUNT_W'(r_char) << SH;
    assign cnt_inc = r_cnt + hsd_pkg::COUNT_W'(1);

    // Next read position: skip parity positions
    always_comb begin
        p_next = r_rp + PW'(1);
        if ((p_next & (p_next - PW'(1))) == '0) begin
            p_next = p_next + PW'(1);
        end
    end

    // Syndrome and parity with the incoming bit
    assign wpos    = r_wp + PW'(1);
    assign par_upd = r_par ^ i_in.code_bit;
    assign syn_upd = (i_in.code_bit && (wpos < blen)) ? (r_syn ^ wpos[LOG2-1:0]) : r_syn;

    // Bit store write port
    assign we    = in_acc && !i_in.mode;
    assign waddr = {r_bank, r_wp[LOG2-1:0]};

    // Step: emit from pending block, then take the code bit; config overrides
    always_comb begin
        n_bsl       = r_bsl;
        n_char      = r_char;
        n_bank      = r_bank;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_syn       = r_syn;
        n_par       = r_par;
        n_pend      = r_pend;
        n_pst       = r_pst;
        n_ppos      = r_ppos;
        n_cnt       = r_cnt;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_obit      = r_obit;
        n_ost       = r_ost;
        n_olast_blk = r_olast_blk;
        n_olast_dat = r_olast_dat;

        if (in_acc) begin
            // Release one data bit of the pending block, or drop it
            if (r_pend) begin
                if (r_cnt >= limit || r_rp > blen_m1 || r_rp < PW'(3)) begin
                    n_pend = 1'b0;
                end else begin
                    n_cnt       = cnt_inc;
                    n_ovalid    = 1'b1;
                    n_obit      = rd_bit ^ ((r_pst == hsd_pkg::ST_FIXED) && (r_rp == r_ppos));
                    n_ost       = r_pst;
                    n_olast_blk = (r_rp == blen_m1);
                    n_olast_dat = (cnt_inc == limit);
                    if (r_rp >= blen_m1) begin
                        n_pend = 1'b0;
                    end else begin
                        n_rp = p_next;
                    end
                end
            end

            // Accumulate the code bit and close the block when full
            if (!i_in.mode) begin
                n_par = par_upd;
                n_syn = syn_upd;
                n_wp  = wpos;
                if (wpos >= blen) begin
                    if (syn_upd == '0 && !par_upd) begin
                        n_pst = hsd_pkg::ST_CLEAN;
                    end else if (syn_upd != '0 && par_upd) begin
                        n_pst = hsd_pkg::ST_FIXED;
                    end else if (syn_upd == '0) begin
                        n_pst = hsd_pkg::ST_PARITY;
                    end else begin
                        n_pst = hsd_pkg::ST_DOUBLE;
                    end
                    n_ppos = (syn_upd == '0 && par_upd) ? blen : PW'(syn_upd);
                    n_pend = 1'b1;
                    n_rp   = PW'(3);
                    n_bank = !r_bank;
                    n_wp   = '0;
                    n_syn  = '0;
                    n_par  = 1'b0;
                end
            end
        end

        // Register writes; block size restarts framing
        if (cfg_acc) begin
            case (i_cfg.index)
                hsd_pkg::CFG_BLOCK_SIZE_LOG2: begin
                    n_bsl  = i_cfg.data[hsd_pkg::BSL_W-1:0];
                    n_wp   = '0;
                    n_rp   = '0;
                    n_syn  = '0;
                    n_par  = 1'b0;
                    n_pend = 1'b0;
                    n_pst  = hsd_pkg::ST_CLEAN;
                    n_ppos = '0;
                end
                hsd_pkg::CFG_CHAR_LIMIT: begin
                    n_char = i_cfg.data[hsd_pkg::CHAR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Prefetch the bit at the next read position of the other bank
    assign rofs  = n_rp - PW'(1);
    assign raddr = {!n_bank, rofs[LOG2-1:0]};

    hsd_ram #(
        .WIDTH (1),
        .DEPTH (2 * MAX_BLOCK)
    ) u_bank_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in.code_bit),
        .i_raddr (raddr),
        .o_rdata (rd_bit)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsl    <= hsd_pkg::BSL_W'(hsd_pkg::LOG2_MIN);
            r_char   <= '0;
            r_bank   <= 1'b0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_syn    <= '0;
            r_par    <= 1'b0;
            r_pend   <= 1'b0;
            r_pst    <= hsd_pkg::ST_CLEAN;
            r_ppos   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_bsl    <= n_bsl;
            r_char   <= n_char;
            r_bank   <= n_bank;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_syn    <= n_syn;
            r_par    <= n_par;
            r_pend   <= n_pend;
            r_pst    <= n_pst;
            r_ppos   <= n_ppos;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_obit      <= n_obit;
        r_ost       <= n_ost;
        r_olast_blk <= n_olast_blk;
        r_olast_dat <= n_olast_dat;
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.data_bit      = r_obit;
    assign o_out.block_status  = r_ost;
    assign o_out.last_in_block = r_olast_blk;
    assign o_out.last_data_bit = r_olast_dat;

endmodule

### sv/hsd_checker.sv
// Port-level checker for the SECDED block decoder, with its bind statement.
// Depends on hsd_pkg and the top level hamming_secded_block_decoder_unit.
module hsd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_data_bit,
    input hsd_pkg::t_status i_out_block_status
);

    // Output stays clear right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_out_data_bit) && $stable(i_out_block_status))
        else $error("stalled result changed");

    // Input stalls only behind a held result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // A new result follows an accepted input transaction
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without input transaction");

endmodule

bind hamming_secded_block_decoder_unit hsd_checker u_hsd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_data_bit     (o_out.data_bit),
    .i_out_block_status (o_out.block_status)
);
